### rtl/gwm_pkg.sv
// Package for the glob wildcard matcher: sizes, character codes, op codes
// and the control bundle broadcast from the core to the row of cells.
// No dependencies.
package gwm_pkg;

  localparam int PATTERN_MAX = 256;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CHR_W       = 8;

  localparam logic [CHR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHR_W-1:0] ANY_CHAR  = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } op_t;

  typedef struct packed {
    logic             clear;
    logic             append;
    logic             restart;
    logic             step;
    logic [LEN_W-1:0] wr_ptr;
    logic [CHR_W-1:0] chr;
  } cell_ctl_t;

endpackage

### rtl/glob_wildcard_matcher_core.sv
// Glob wildcard matcher: row of pattern cells, star closure and result register.
// Results reach out_ the cycle after end-of-subject; one item per cycle unless
// a result stalls on out_. All positions update at once from the closed active
// set, the closure over star runs being one carry chain across the row.
// Reset: empty pattern, overflow clear, only position zero active, no result.
// Depends on gwm_pkg and gwm_cell.
module glob_wildcard_matcher_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] chr
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_overflow, [7:2] zero
);
  import gwm_pkg::*;

  op_t                  op;
  logic                 in_xfer;
  cell_ctl_t            ctl;
  logic [LEN_W-1:0]     len_r;
  logic [LEN_W-1:0]     len_nxt;
  logic                 ovf_r;
  logic                 ovf_nxt;
  logic                 act_end_r;
  logic                 act_end_nxt;
  logic                 full;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 matched_r;
  logic                 ovf_out_r;
  logic [PATTERN_MAX-1:0] act_w;
  logic [PATTERN_MAX-1:0] star_w;
  logic [PATTERN_MAX-1:0] adv_w;
  logic [PATTERN_MAX:0]   gen_w;
  logic [PATTERN_MAX:0]   prop_w;
  logic [PATTERN_MAX:0]   genp_w;
  logic [PATTERN_MAX+1:0] sum_w;
  logic [PATTERN_MAX+1:0] carry_w;
  logic [PATTERN_MAX:0]   closed_w;

  assign op        = op_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign full      = (len_r == LEN_W'(PATTERN_MAX));

  assign ctl.clear   = in_xfer && (op == OP_CLEAR);
  assign ctl.append  = in_xfer && (op == OP_APPEND) && !full;
  assign ctl.restart = in_xfer && (op != OP_SUBJECT);
  assign ctl.step    = in_xfer && (op == OP_SUBJECT);
  assign ctl.wr_ptr  = len_r;
  assign ctl.chr     = in_tdata;

  assign gen_w    = {act_end_r, act_w};
  assign prop_w   = {1'b0, star_w};
  assign genp_w   = gen_w & prop_w;
  assign sum_w    = {1'b0, prop_w} + {1'b0, genp_w};
  assign carry_w  = sum_w ^ {1'b0, prop_w} ^ {1'b0, genp_w};
  assign closed_w = gen_w | carry_w[PATTERN_MAX:0];

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic adv_prev;
    if (i == 0) begin : g_first
      assign adv_prev = 1'b0;
    end else begin : g_rest
      assign adv_prev = adv_w[i-1];
    end
    gwm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IDX_W'(i)),
      .ctl       (ctl),
      .closed_in (closed_w[i]),
      .adv_in    (adv_prev),
      .act_out   (act_w[i]),
      .star_out  (star_w[i]),
      .adv_out   (adv_w[i])
    );
  end

  always_comb begin
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    act_end_nxt   = act_end_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.clear) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end
    if (in_xfer && op == OP_APPEND) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        len_nxt = len_r + LEN_W'(1);
      end
    end
    if (ctl.restart) begin
      act_end_nxt = 1'b0;
    end else if (ctl.step) begin
      act_end_nxt = adv_w[PATTERN_MAX-1];
    end
    if (in_xfer && op == OP_END) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      act_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      act_end_r   <= act_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && op == OP_END) begin
      matched_r <= closed_w[len_r];
      ovf_out_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, ovf_out_r, matched_r};

endmodule

### rtl/gwm_cell.sv
// One pattern position of the matcher: stored byte, fill flag, active bit.
// Depends on gwm_pkg.
module gwm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gwm_pkg::IDX_W-1:0] cell_idx,
  input  gwm_pkg::cell_ctl_t        ctl,
  input  logic                      closed_in,
  input  logic                      adv_in,
  output logic                      act_out,
  output logic                      star_out,
  output logic                      adv_out
);
  import gwm_pkg::*;

  logic [CHR_W-1:0] chr_r;
  logic             filled_r;
  logic             filled_nxt;
  logic             act_r;
  logic             act_nxt;
  logic             wr_hit;
  logic             is_star;
  logic             is_match;

  assign wr_hit   = ctl.append && (LEN_W'(cell_idx) == ctl.wr_ptr);
  assign is_star  = filled_r && (chr_r == STAR_CHAR);
  assign is_match = filled_r && !is_star && (chr_r == ANY_CHAR || chr_r == ctl.chr);

  assign star_out = is_star;
  assign adv_out  = closed_in && is_match;
  assign act_out  = act_r;

  always_comb begin
    filled_nxt = filled_r;
    if (ctl.clear) begin
      filled_nxt = 1'b0;
    end else if (wr_hit) begin
      filled_nxt = 1'b1;
    end
    act_nxt = act_r;
    if (ctl.restart) begin
      act_nxt = (cell_idx == '0);
    end else if (ctl.step) begin
      act_nxt = adv_in || (closed_in && is_star);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
      act_r    <= (cell_idx == '0);
    end else begin
      filled_r <= filled_nxt;
      act_r    <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      chr_r <= ctl.chr;
    end
  end

endmodule

### rtl/gwm_checker.sv
// Port-level checks for the glob wildcard matcher, bound to the core.
// Depends on gwm_pkg and glob_wildcard_matcher_core.
module gwm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import gwm_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == OP_END |=> out_tvalid)
    else $error("end of subject gave no result");

  a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == OP_CLEAR) ##1 (in_xfer && in_tuser == OP_END)
      |=> out_tdata[1:0] == 2'b01)
    else $error("empty pattern did not match empty subject");

  a_no_other_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_xfer && in_tuser == OP_END) && out_tvalid && out_tready |=> !out_tvalid)
    else $error("result without end of subject");

endmodule

bind glob_wildcard_matcher_core gwm_checker u_gwm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
